// ===== rtl/tlr_pkg.sv =====
// Shared types and constants for the terminated line receiver.
// No dependencies; imported by every module of the block except tlr_ram.
package tlr_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam logic [7:0] END_BYTE_RST = 8'd10;

	// APB register map: index = paddr[PADDR_W-1:2]
	localparam int PADDR_W = 3;
	localparam logic REG_END_BYTE = 1'b0;

	typedef enum logic {
		REQ_BYTE  = 1'b0,
		REQ_FETCH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_WAITING = 2'd0,
		ST_SUCCESS = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} fsm_t;

	typedef struct packed {
		req_t       req_type;
		logic [7:0] rx_byte;
		logic [7:0] read_limit;
	} in_word_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data;
		logic       data_valid;
		logic       last;
	} out_word_t;

	// Controller -> output queue
	typedef struct packed {
		logic      push;
		out_word_t word;
	} oq_push_t;

	// Output queue -> controller
	typedef struct packed {
		logic [1:0] level;
		logic       pop;
	} oq_stat_t;

endpackage

// ===== rtl/tlr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tlr_out_fifo.sv =====
// Two-entry result queue that decouples the line store read from the output.
// Depends on tlr_pkg.
module tlr_out_fifo
	import tlr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  oq_push_t  push,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word,
	output oq_stat_t  stat
);

	out_word_t  ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] level_q;
	logic       pop;

	assign out_valid  = (level_q != 2'd0);
	assign out_word   = ent_q[rp_q];
	assign pop        = out_valid & out_ready;
	assign stat.level = level_q;
	assign stat.pop   = pop;

	always_ff @(posedge clk) begin
		if (push.push) begin
			ent_q[wp_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push.push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			level_q <= level_q + {1'b0, push.push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/tlr_ctrl.sv =====
// Line controller: fill count, flags, store writes and fetch streaming.
// Depends on tlr_pkg and tlr_ram.
module tlr_ctrl
	import tlr_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_word,
	input  logic [7:0] end_byte,
	input  oq_stat_t   oq_stat,
	output oq_push_t   oq_push
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	fsm_t                   state_q, state_d;
	logic [CW-1:0]          fill_q;
	logic                   closed_q;
	logic                   error_q;
	logic [STORE_DEPTH-1:0] vld_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          last_idx_q;

	logic      pend_s1;
	out_word_t res_s1;
	logic      hit_s1;

	logic       room;
	logic [2:0] inflight;
	logic       acc_byte;
	logic       acc_fetch;
	logic       is_end;
	logic       we;
	logic [7:0] wdata;
	logic [7:0] rdata;
	logic       re;
	logic       issue;
	out_word_t  issue_res;
	logic [7:0] lim_clamp;
	logic       reopen;

	// slots taken in the queue, counting the read in flight
	assign inflight = {1'b0, oq_stat.level} + {2'b0, pend_s1} - {2'b0, oq_stat.pop};
	assign room     = (inflight < 3'd2);

	assign acc_byte  = in_valid & in_ready & (in_word.req_type == REQ_BYTE);
	assign acc_fetch = in_valid & in_ready & (in_word.req_type == REQ_FETCH);
	assign is_end    = (in_word.rx_byte == end_byte);
	assign we        = acc_byte & ~closed_q &
		((is_end & (fill_q < CW'(STORE_DEPTH))) |
		 (~is_end & (fill_q < CW'(STORE_DEPTH - 1))));
	assign wdata     = is_end ? 8'h00 : in_word.rx_byte;
	assign lim_clamp = (in_word.read_limit > 8'(STORE_DEPTH)) ?
		8'(STORE_DEPTH) : in_word.read_limit;
	assign reopen    = acc_fetch & closed_q & ~error_q;

	tlr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(fill_q[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		issue     = 1'b0;
		re        = 1'b0;
		issue_res = '{status: ST_SUCCESS, data: 8'h00, data_valid: 1'b0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				in_ready = room;
				if (acc_fetch) begin
					if (!closed_q) begin
						issue            = 1'b1;
						issue_res.status = ST_WAITING;
					end else if (error_q) begin
						issue            = 1'b1;
						issue_res.status = ST_ERROR;
					end else if (lim_clamp == 8'd0) begin
						issue = 1'b1;
					end else begin
						state_d = S_STREAM;
					end
				end
			end
			S_STREAM: begin
				if (room) begin
					issue                = 1'b1;
					re                   = 1'b1;
					issue_res.data_valid = 1'b1;
					issue_res.last       = (ptr_q == last_idx_q);
					if (ptr_q == last_idx_q) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			closed_q <= 1'b0;
			error_q  <= 1'b0;
			vld_q    <= '0;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (acc_byte && !closed_q) begin
				if (is_end) begin
					closed_q <= 1'b1;
				end else if (fill_q >= CW'(STORE_DEPTH - 1)) begin
					closed_q <= 1'b1;
					error_q  <= 1'b1;
				end
			end
			if (we) begin
				fill_q                <= fill_q + CW'(1);
				vld_q[fill_q[AW-1:0]] <= 1'b1;
			end
			if (reopen) begin
				fill_q   <= '0;
				closed_q <= 1'b0;
				ptr_q    <= '0;
			end else if (re) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// payload of the stage that waits on the store read
	always_ff @(posedge clk) begin
		if (reopen) begin
			last_idx_q <= AW'(lim_clamp - 8'd1);
		end
		if (issue) begin
			res_s1 <= issue_res;
			hit_s1 <= re & vld_q[ptr_q];
		end
	end

	// never-written entries read as zero
	always_comb begin
		oq_push.push = pend_s1;
		oq_push.word = res_s1;
		oq_push.word.data = (res_s1.data_valid && hit_s1) ? rdata : 8'h00;
	end

endmodule

// ===== rtl/terminated_line_receiver_top.sv =====
// Terminated line receiver top: APB end-byte register, controller, result queue.
// A received byte is stored at its accept edge. A status answer goes through the
// read stage register, then the result queue. A streamed line enters S_STREAM; each
// byte goes through the store read and the queue, one per cycle while out_ready
// holds. Throughput: one item per cycle while the queue has room; none in S_STREAM.
// Reset: flags, fill count and store valid bits clear at once; no clearing pass.
module terminated_line_receiver_top
	import tlr_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [7:0] end_byte_q;
	logic       reg_idx;
	logic       cfg_wr;
	oq_push_t   oq_push;
	oq_stat_t   oq_stat;

	// APB: zero-wait, register index taken from the word address
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q <= END_BYTE_RST;
		end else if (cfg_wr && reg_idx == REG_END_BYTE) begin
			end_byte_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_END_BYTE: prdata = {24'h0, end_byte_q};
			default:      prdata = 32'h0;
		endcase
	end

	// Line state, store and fetch sequencer
	tlr_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word (in_word),
		.end_byte(end_byte_q),
		.oq_stat (oq_stat),
		.oq_push (oq_push)
	);

	// Results wait here so a store read in flight can land under backpressure
	tlr_out_fifo u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (oq_push),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.stat     (oq_stat)
	);

	// Credit check: the queue is never pushed while full and not draining
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(oq_push.push && oq_stat.level == 2'd2 && !oq_stat.pop))
		else $error("result queue overflow");

	// Line bytes only ever come with a success status
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.data_valid) |-> (out_word.status == ST_SUCCESS))
		else $error("line byte with non-success status");

	// Status-only answers always end the fetch
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.data_valid) |-> out_word.last)
		else $error("status word without last");

	// End byte register takes the APB write
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == REG_END_BYTE) |=> (end_byte_q == $past(pwdata[7:0])))
		else $error("end byte write lost");

endmodule

// ===== bench/terminated_line_receiver_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for terminated_line_receiver_top: line capture, fetch streaming, overflow.
// Depends on tlr_pkg and the RTL top only; drives words and APB, checks results and read back.
module terminated_line_receiver_top_tb
	import tlr_pkg::*;
();

	localparam int DEPTH = STORE_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000; // cycles without any accepted word
	localparam int PHASE_WORDS = 32;
	localparam int NUM_PHASES = 5;
	localparam logic [PADDR_W-1:0] END_BYTE_ADDR = {REG_END_BYTE, 2'b00};

	// Mirror of the line store plus the queue of result words each fetch must produce.
	class line_fetch_scoreboard;
		logic [7:0] line_bytes [DEPTH];
		int         line_len;
		bit         line_closed;
		bit         line_overflow;
		logic [7:0] term_byte;
		out_word_t  expected_words [$];
		int         mismatches;

		function new();
			foreach (line_bytes[i]) line_bytes[i] = 8'h00;
			line_len = 0;
			line_closed = 1'b0;
			line_overflow = 1'b0;
			term_byte = END_BYTE_RST;
			mismatches = 0;
		endfunction

		function out_word_t result_word(status_t st, logic [7:0] d, logic dv, logic lst);
			out_word_t w;
			w.status = st;
			w.data = d;
			w.data_valid = dv;
			w.last = lst;
			return w;
		endfunction

		function void note_input(in_word_t w);
			int n;
			if (w.req_type == REQ_BYTE) begin
				// received bytes never produce a result word
				if (line_closed)
					return;
				if (w.rx_byte == term_byte) begin
					// terminator lands as a zero byte if there is room
					if (line_len < DEPTH) begin
						line_bytes[line_len] = 8'h00;
						line_len++;
					end
					line_closed = 1'b1;
				end else if (line_len >= DEPTH - 1) begin
					line_closed = 1'b1;
					line_overflow = 1'b1;
				end else begin
					line_bytes[line_len] = w.rx_byte;
					line_len++;
				end
			end else if (!line_closed) begin
				expected_words.push_back(result_word(ST_WAITING, 8'h00, 1'b0, 1'b1));
			end else if (line_overflow) begin
				expected_words.push_back(result_word(ST_ERROR, 8'h00, 1'b0, 1'b1));
			end else begin
				n = (w.read_limit > DEPTH) ? DEPTH : int'(w.read_limit);
				line_len = 0;
				line_closed = 1'b0;
				if (n == 0)
					expected_words.push_back(result_word(ST_SUCCESS, 8'h00, 1'b0, 1'b1));
				for (int i = 0; i < n; i++)
					expected_words.push_back(result_word(ST_SUCCESS, line_bytes[i], 1'b1,
						i == n - 1));
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				$error("result word %h with nothing expected", got);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.data !== want.data) begin
				$error("data: expected %h, got %h", want.data, got.data);
				mismatches++;
			end
			if (got.data_valid !== want.data_valid) begin
				$error("data_valid: expected %b, got %b", want.data_valid, got.data_valid);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %b, got %b", want.last, got.last);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_word_t           in_word;
	logic               out_valid;
	logic               out_ready;
	out_word_t          out_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	line_fetch_scoreboard fetch_sb;
	bit calm;            // when set, neither side inserts idle cycles
	int reg_errors;
	int stuck_cycles;

	terminated_line_receiver_top #(
		.STORE_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle length: mostly none, often a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Random byte that is guaranteed not to be the current terminator.
	function automatic logic [7:0] other_byte();
		logic [7:0] b;
		b = 8'($urandom());
		if (b == fetch_sb.term_byte)
			b = ~b;
		return b;
	endfunction

	// Drive one input word. Entered right after a rising edge; returns right after
	// the edge that accepted it. Valid is only dropped when a gap is inserted, so
	// back-to-back words keep valid high without a low/high pair in one step.
	task automatic push_word(input req_t req, input logic [7:0] b, input logic [7:0] lim);
		in_word_t w;
		int gap;
		w.req_type = req;
		w.rx_byte = b;
		w.read_limit = lim;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		fetch_sb.note_input(w);
	endtask

	task automatic send_byte(input logic [7:0] b);
		push_word(REQ_BYTE, b, 8'($urandom()));
	endtask

	task automatic send_fetch(input logic [7:0] lim);
		push_word(REQ_FETCH, 8'($urandom()), lim);
	endtask

	// Block goes idle: every expected word in, then a few cycles for a byte that
	// produces no result to finish landing in the store.
	task automatic settle();
		in_valid <= 1'b0;
		while (fetch_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write of the end byte, followed by a read back of the same register.
	task automatic write_end_byte(input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= END_BYTE_ADDR;
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		fetch_sb.term_byte = val;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'd0, val}) begin
			$error("end_byte read back: expected %h, got %h", {24'd0, val}, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: random ready stalls, sampled together with valid at each edge.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin : ready_loop
			int gap;
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			fetch_sb.check_result(out_word);
	end

	// Watchdog: a run that stops accepting words on both sides is a hang.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int count;
		int pick;
		int room;
		int len;
		int k;
		int r;
		logic [7:0] lim;

		fetch_sb = new();
		calm = 1'b0;
		reg_errors = 0;
		stuck_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset terminator in force.
		send_fetch(8'hFF);               // nothing received yet: waiting
		send_fetch(8'h00);               // still waiting with a zero limit
		send_byte(8'h00);                // field extremes go into the store
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(fetch_sb.term_byte);   // closes the line, stored as zero
		send_byte(8'h33);                // ignored while closed
		send_byte(fetch_sb.term_byte);   // terminator while closed is ignored too
		send_fetch(8'd3);                // short read of a longer line, reopens
		send_fetch(8'd1);                // reopened and empty: waiting
		send_byte(8'h7E);
		send_byte(fetch_sb.term_byte);
		send_fetch(8'd0);                // zero limit: one success word, no data
		send_byte(fetch_sb.term_byte);   // empty line
		send_fetch(8'hFF);               // clamped to store size, stale bytes come out
		send_byte(8'h81);
		send_byte(fetch_sb.term_byte);
		send_fetch(8'd64);               // exactly the store size
		send_byte(8'h18);
		send_byte(fetch_sb.term_byte);
		send_fetch(8'd65);               // one above the store size

		// Random phases, each under its own terminator; one phase runs with no idling.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			calm = (phase == 2);
			case (phase)
				0: write_end_byte(8'h00);
				1: write_end_byte(8'hFF);
				NUM_PHASES - 1: write_end_byte(END_BYTE_RST);
				default: write_end_byte(8'($urandom()));
			endcase
			count = 0;
			while (count < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// well-formed line: optional drain fetch, body, terminator, optional stray bytes, fetch
					if (fetch_sb.line_closed) begin
						send_fetch(8'($urandom()));
						count++;
					end
					room = DEPTH - 1 - fetch_sb.line_len;
					if ($urandom_range(0, 99) < 85)
						len = $urandom_range(0, 8);
					else
						len = $urandom_range((room > 3) ? room - 3 : 0, room);
					if (len > room)
						len = room;
					repeat (len) send_byte(other_byte());
					send_byte(fetch_sb.term_byte);
					if ($urandom_range(0, 99) < 20)
						repeat ($urandom_range(1, 2)) send_byte(8'($urandom()));
					r = $urandom_range(0, 99);
					if (r < 20)
						lim = 8'd0;
					else if (r < 55)
						lim = 8'($urandom_range(1, len + 2));
					else if (r < 75)
						lim = 8'($urandom_range(DEPTH - 2, DEPTH + 2));
					else
						lim = 8'($urandom());
					send_fetch(lim);
					count += len + 2;
				end else if (pick < 85 || fetch_sb.line_len >= 50) begin
					send_fetch(8'($urandom()));
					count++;
				end else begin
					// noise: loose bytes, now and then a stray terminator
					k = $urandom_range(1, 4);
					repeat (k) begin
						if ($urandom_range(0, 3) == 0)
							send_byte(fetch_sb.term_byte);
						else
							send_byte(8'($urandom()));
					end
					count += k;
				end
			end
		end

		// Overflow last, since the error never clears without a reset.
		calm = 1'b0;
		if (fetch_sb.line_closed)
			send_fetch(8'd0);
		while (!fetch_sb.line_closed)
			send_byte(other_byte());
		send_fetch(8'($urandom()));      // error answer
		send_byte(fetch_sb.term_byte);   // ignored, line stays in error
		send_fetch(8'd0);
		send_fetch(8'hFF);

		settle();
		if (fetch_sb.mismatches == 0 && reg_errors == 0 && fetch_sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tlr_pkg.sv
rtl/tlr_ram.sv
rtl/tlr_out_fifo.sv
rtl/tlr_ctrl.sv
rtl/terminated_line_receiver_top.sv
bench/terminated_line_receiver_top_tb.sv
